// ===== src/pfd_pkg.sv =====
// ----------------------------------------------------------------------------
// pfd_pkg: shared constants for the pose frame deframer
// Frame delimiters, payload geometry and result word width.
// ----------------------------------------------------------------------------
package pfd_pkg;

	localparam int unsigned BYTE_W      = 8;
	localparam int unsigned WORD_W      = 32;
	localparam int unsigned PAYLOAD_LEN = 24;
	localparam int unsigned STORE_W     = PAYLOAD_LEN * BYTE_W;
	localparam int unsigned IDX_W       = $clog2(PAYLOAD_LEN);

	// Header is CR LF, trailer is LF CR.
	localparam logic [BYTE_W-1:0] HDR_FIRST  = 8'h0D;
	localparam logic [BYTE_W-1:0] HDR_SECOND = 8'h0A;
	localparam logic [BYTE_W-1:0] TRL_FIRST  = 8'h0A;
	localparam logic [BYTE_W-1:0] TRL_SECOND = 8'h0D;

endpackage

// ===== src/pfd_if.sv =====
// ----------------------------------------------------------------------------
// pfd_if: stream channels of the pose frame deframer
// A byte channel for received serial data and a pose channel for results.
// ----------------------------------------------------------------------------
interface pfd_byte_if import pfd_pkg::*; ();
	logic              valid;
	logic              ready;
	logic [BYTE_W-1:0] rx_byte;

	modport source (output valid, output rx_byte, input ready);
	modport sink   (input valid, input rx_byte, output ready);
endinterface

interface pfd_pose_if import pfd_pkg::*; ();
	logic              valid;
	logic              ready;
	logic [WORD_W-1:0] heading_bits;
	logic [WORD_W-1:0] tilt_x_bits;
	logic [WORD_W-1:0] tilt_y_bits;
	logic [WORD_W-1:0] position_x_bits;
	logic [WORD_W-1:0] position_y_bits;
	logic [WORD_W-1:0] yaw_rate_bits;

	modport source (
		output valid, input ready,
		output heading_bits, output tilt_x_bits, output tilt_y_bits,
		output position_x_bits, output position_y_bits, output yaw_rate_bits
	);
	modport sink (
		input valid, output ready,
		input heading_bits, input tilt_x_bits, input tilt_y_bits,
		input position_x_bits, input position_y_bits, input yaw_rate_bits
	);
endinterface

// ===== src/pose_frame_deframer_top.sv =====
// ----------------------------------------------------------------------------
// pose_frame_deframer_top: byte-serial deframer for fixed-length pose frames
// Hunts for CR LF, collects 24 payload bytes, checks LF CR and emits six words.
// ----------------------------------------------------------------------------
// Usage:
// The rx channel takes one received byte per transfer. The pose channel gives
// one result per well-formed frame: six 32-bit words assembled little-endian
// from the payload, passed on as raw single-precision float bits.
// A byte is taken in every cycle while the pose output register is empty or
// is being emptied in the same cycle, so the sustained rate is one byte per
// cycle. The frame state machine and the payload shift line update at the
// byte transfer itself.
// The result is valid in the cycle after the transfer of the final trailer
// byte (CR), held in the pose output register.
// When the receiver stalls with a result pending, rx.ready drops and stays low
// until that result is transferred; no byte is lost or dropped.
// Reset clears the frame state, the payload counter and the output valid flag.
// The payload shift line is not reset; every frame refills all of it before a
// result can be produced.
// ----------------------------------------------------------------------------
module pose_frame_deframer_top import pfd_pkg::*; (
	input  logic         clk,
	input  logic         arst_n,
	pfd_byte_if.sink     rx,
	pfd_pose_if.source   pose
);

	typedef enum logic [2:0] {
		PH_HUNT,
		PH_HDR2,
		PH_DATA,
		PH_TRL1,
		PH_TRL2
	} phase_t;

	phase_t             phase_q;
	logic [IDX_W-1:0]   idx_q;
	logic [STORE_W-1:0] store_q;
	logic               pose_valid_q;
	logic [WORD_W-1:0]  heading_q;
	logic [WORD_W-1:0]  tilt_x_q;
	logic [WORD_W-1:0]  tilt_y_q;
	logic [WORD_W-1:0]  pos_x_q;
	logic [WORD_W-1:0]  pos_y_q;
	logic [WORD_W-1:0]  yaw_rate_q;

	logic out_free;
	logic accept;
	logic frame_done;

	// The output register can take a new result when it is empty or being
	// drained right now.
	assign out_free   = !pose_valid_q || pose.ready;
	assign rx.ready   = out_free;
	assign accept     = rx.valid && out_free;
	assign frame_done = accept && (phase_q == PH_TRL2) && (rx.rx_byte == TRL_SECOND);

	// Frame state machine, payload counter and output valid flag.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q      <= PH_HUNT;
			idx_q        <= '0;
			pose_valid_q <= 1'b0;
		end else begin
			if (accept) begin
				unique case (phase_q)
					PH_HUNT: begin
						if (rx.rx_byte == HDR_FIRST) begin
							phase_q <= PH_HDR2;
						end
					end
					PH_HDR2: begin
						// A repeated CR keeps waiting for the LF.
						if (rx.rx_byte == HDR_SECOND) begin
							idx_q   <= '0;
							phase_q <= PH_DATA;
						end else if (rx.rx_byte != HDR_FIRST) begin
							phase_q <= PH_HUNT;
						end
					end
					PH_DATA: begin
						if (idx_q == IDX_W'(PAYLOAD_LEN - 1)) begin
							idx_q   <= '0;
							phase_q <= PH_TRL1;
						end else begin
							idx_q <= idx_q + 1'b1;
						end
					end
					PH_TRL1: begin
						phase_q <= (rx.rx_byte == TRL_FIRST) ? PH_TRL2 : PH_HUNT;
					end
					PH_TRL2: begin
						phase_q <= PH_HUNT;
					end
					default: begin
						phase_q <= PH_HUNT;
					end
				endcase
			end
			if (frame_done) begin
				pose_valid_q <= 1'b1;
			end else if (pose.ready) begin
				pose_valid_q <= 1'b0;
			end
		end
	end

	// Payload bytes shift in from the top, so after a full payload the first
	// byte sits in the lowest byte lane and each word is a plain slice.
	always_ff @(posedge clk) begin
		if (accept && (phase_q == PH_DATA)) begin
			store_q <= {rx.rx_byte, store_q[STORE_W-1:BYTE_W]};
		end
		if (frame_done) begin
			heading_q  <= store_q[0*WORD_W +: WORD_W];
			tilt_x_q   <= store_q[1*WORD_W +: WORD_W];
			tilt_y_q   <= store_q[2*WORD_W +: WORD_W];
			pos_x_q    <= store_q[3*WORD_W +: WORD_W];
			pos_y_q    <= store_q[4*WORD_W +: WORD_W];
			yaw_rate_q <= store_q[5*WORD_W +: WORD_W];
		end
	end

	assign pose.valid           = pose_valid_q;
	assign pose.heading_bits    = heading_q;
	assign pose.tilt_x_bits     = tilt_x_q;
	assign pose.tilt_y_bits     = tilt_y_q;
	assign pose.position_x_bits = pos_x_q;
	assign pose.position_y_bits = pos_y_q;
	assign pose.yaw_rate_bits   = yaw_rate_q;

endmodule

// ===== src/pfd_checker.sv =====
// ----------------------------------------------------------------------------
// pfd_checker: port-level assertions for the pose frame deframer
// Watches the rx and pose channels of the top level over time.
// ----------------------------------------------------------------------------
module pfd_checker import pfd_pkg::*; (
	input logic              clk,
	input logic              arst_n,
	input logic              in_valid,
	input logic              in_ready,
	input logic [BYTE_W-1:0] in_byte,
	input logic              out_valid,
	input logic              out_ready,
	input logic [WORD_W-1:0] out_heading
);

	// With no result pending the block always takes a byte.
	a_ready_when_empty: assert property (@(posedge clk) disable iff (!arst_n)
		!out_valid |-> in_ready)
		else $error("rx not ready while no result is pending");

	// A stalled result blocks the byte channel.
	a_stall_blocks_input: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && !out_ready) |-> !in_ready)
		else $error("byte taken while a result is stalled");

	// A new result only follows the transfer of a trailer CR.
	a_result_after_cr: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(out_valid) |-> $past(in_valid && in_ready && (in_byte == TRL_SECOND)))
		else $error("result without a closing trailer byte");

	// A stalled result holds its value.
	a_result_holds: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && !out_ready) |=> (out_valid && $stable(out_heading)))
		else $error("stalled result changed or vanished");

endmodule

bind pose_frame_deframer_top pfd_checker u_pfd_checker (
	.clk         (clk),
	.arst_n      (arst_n),
	.in_valid    (rx.valid),
	.in_ready    (rx.ready),
	.in_byte     (rx.rx_byte),
	.out_valid   (pose.valid),
	.out_ready   (pose.ready),
	.out_heading (pose.heading_bits)
);

// ===== bench/pose_frame_checker.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pose_frame_checker: frame prediction and result comparison
// Watches the byte and pose channels of the pose frame deframer. It tracks
// the framing state from every accepted byte, queues the pose that each good
// frame must give, and compares every pose transfer against the oldest one.
// ----------------------------------------------------------------------------
module pose_frame_checker import pfd_pkg::*; (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              rx_valid,
	input  logic              rx_ready,
	input  logic [BYTE_W-1:0] rx_byte,
	input  logic              pose_valid,
	input  logic              pose_ready,
	input  logic [WORD_W-1:0] heading_bits,
	input  logic [WORD_W-1:0] tilt_x_bits,
	input  logic [WORD_W-1:0] tilt_y_bits,
	input  logic [WORD_W-1:0] position_x_bits,
	input  logic [WORD_W-1:0] position_y_bits,
	input  logic [WORD_W-1:0] yaw_rate_bits,
	output int                mismatch_count,
	output int                expected_pending,
	output int                poses_checked
);

	typedef enum logic [2:0] {
		HUNT_CR,
		WAIT_LF,
		TAKE_PAYLOAD,
		WAIT_TRAIL_LF,
		WAIT_TRAIL_CR
	} frame_phase_e;

	typedef struct packed {
		logic [WORD_W-1:0] heading;
		logic [WORD_W-1:0] tilt_x;
		logic [WORD_W-1:0] tilt_y;
		logic [WORD_W-1:0] position_x;
		logic [WORD_W-1:0] position_y;
		logic [WORD_W-1:0] yaw_rate;
	} pose_words_t;

	frame_phase_e      phase;
	int unsigned       fill_index;
	logic [BYTE_W-1:0] payload [PAYLOAD_LEN];
	pose_words_t       expected_poses [$];

	function automatic logic [WORD_W-1:0] le_word(input int unsigned base);
		return {payload[base+3], payload[base+2], payload[base+1], payload[base]};
	endfunction

	task automatic advance_deframer(input logic [BYTE_W-1:0] b);
		pose_words_t frame;
		case (phase)
			HUNT_CR: begin
				if (b == HDR_FIRST)
					phase = WAIT_LF;
			end
			WAIT_LF: begin
				if (b == HDR_SECOND) begin
					fill_index = 0;
					phase = TAKE_PAYLOAD;
				end else if (b != HDR_FIRST) begin
					phase = HUNT_CR;
				end
			end
			TAKE_PAYLOAD: begin
				payload[fill_index] = b;
				fill_index++;
				if (fill_index == PAYLOAD_LEN) begin
					fill_index = 0;
					phase = WAIT_TRAIL_LF;
				end
			end
			WAIT_TRAIL_LF: begin
				phase = (b == TRL_FIRST) ? WAIT_TRAIL_CR : HUNT_CR;
			end
			WAIT_TRAIL_CR: begin
				if (b == TRL_SECOND) begin
					frame.heading    = le_word(0);
					frame.tilt_x     = le_word(4);
					frame.tilt_y     = le_word(8);
					frame.position_x = le_word(12);
					frame.position_y = le_word(16);
					frame.yaw_rate   = le_word(20);
					expected_poses.push_back(frame);
				end
				phase = HUNT_CR;
			end
			default: begin
				phase = HUNT_CR;
			end
		endcase
	endtask

	task automatic check_word(input string field, input logic [WORD_W-1:0] exp_word,
			input logic [WORD_W-1:0] act_word);
		if (act_word !== exp_word) begin
			$error("%s: expected %h, got %h", field, exp_word, act_word);
			mismatch_count++;
		end
	endtask

	always @(posedge clk or negedge arst_n) begin
		pose_words_t oldest;
		if (!arst_n) begin
			phase = HUNT_CR;
			fill_index = 0;
			expected_poses.delete();
			expected_pending = 0;
			mismatch_count = 0;
			poses_checked = 0;
		end else begin
			// The pose of a frame shows up in the cycle after its last byte, so
			// the result side is settled before the byte side moves on.
			if (pose_valid && pose_ready) begin
				if (expected_poses.size() == 0) begin
					$error("pose transfer with no frame outstanding, heading %h",
						heading_bits);
					mismatch_count++;
				end else begin
					oldest = expected_poses.pop_front();
					check_word("heading_bits", oldest.heading, heading_bits);
					check_word("tilt_x_bits", oldest.tilt_x, tilt_x_bits);
					check_word("tilt_y_bits", oldest.tilt_y, tilt_y_bits);
					check_word("position_x_bits", oldest.position_x, position_x_bits);
					check_word("position_y_bits", oldest.position_y, position_y_bits);
					check_word("yaw_rate_bits", oldest.yaw_rate, yaw_rate_bits);
					poses_checked++;
				end
			end
			if (rx_valid && rx_ready)
				advance_deframer(rx_byte);
			expected_pending = expected_poses.size();
		end
	end

endmodule

// ===== bench/pose_frame_deframer_top_tb.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pose_frame_deframer_top_tb: stimulus and verdict for the pose frame deframer
// Sends a directed frame with corner payload bytes, then a long random mix of
// clean frames, frames with broken headers or trailers, cut-off frames and
// line noise, while both channels idle at random. A separate checker predicts
// and compares every pose; this module only drives and gives the verdict.
// ----------------------------------------------------------------------------
module pose_frame_deframer_top_tb;
	import pfd_pkg::*;

	// The run stops offering frames once this many bytes have been accepted.
	localparam int BYTE_TARGET  = 1200;
	// Slowest correct run is roughly 1300 bytes with their idle gaps, plus the
	// output stalls and the long hold; the limit is many times that.
	localparam int CYCLE_LIMIT  = 200000;
	localparam int MAX_IDLE     = 12;
	localparam int LONG_HOLD    = 600;
	localparam int DRAIN_CYCLES = 8;
	localparam int HOLD_AFTER   = 8;

	// Shapes of the byte sequences sent in the random part.
	typedef enum int {
		FRAME_CLEAN,
		FRAME_CR_RUN,
		FRAME_BAD_HDR,
		FRAME_BAD_TRAIL_LF,
		FRAME_BAD_TRAIL_CR,
		FRAME_CUT_SHORT,
		LINE_NOISE
	} frame_kind_e;

	logic clk = 1'b0;
	logic arst_n;

	pfd_byte_if rx_ch ();
	pfd_pose_if pose_ch ();

	int mismatch_count;
	int expected_pending;
	int poses_checked;
	int bytes_sent = 0;
	int broken_frames = 0;
	int cycle_count = 0;
	bit rx_burst = 1'b0;
	bit pose_burst = 1'b0;
	bit long_hold_done = 1'b0;

	// Corner payload values: all zeros, all ones, and the two delimiter bytes,
	// which must pass through the payload untouched.
	logic [BYTE_W-1:0] corner_bytes [4] = '{8'h00, 8'hFF, HDR_FIRST, HDR_SECOND};

	pose_frame_deframer_top uut (
		.clk    (clk),
		.arst_n (arst_n),
		.rx     (rx_ch),
		.pose   (pose_ch)
	);

	pose_frame_checker frame_watch (
		.clk              (clk),
		.arst_n           (arst_n),
		.rx_valid         (rx_ch.valid),
		.rx_ready         (rx_ch.ready),
		.rx_byte          (rx_ch.rx_byte),
		.pose_valid       (pose_ch.valid),
		.pose_ready       (pose_ch.ready),
		.heading_bits     (pose_ch.heading_bits),
		.tilt_x_bits      (pose_ch.tilt_x_bits),
		.tilt_y_bits      (pose_ch.tilt_y_bits),
		.position_x_bits  (pose_ch.position_x_bits),
		.position_y_bits  (pose_ch.position_y_bits),
		.yaw_rate_bits    (pose_ch.yaw_rate_bits),
		.mismatch_count   (mismatch_count),
		.expected_pending (expected_pending),
		.poses_checked    (poses_checked)
	);

	// Free-running clock with a 2 ns period.
	always begin
		#1 clk = 1'b1;
		#1 clk = 1'b0;
	end

	// Watchdog: a hung handshake ends the run as a failure.
	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count >= CYCLE_LIMIT) begin
			$display("FAILURE");
			$finish;
		end
	end

	// Offers one byte after a random idle gap and returns once the transfer
	// has happened. Valid stays high into the next byte when there is no gap,
	// so back-to-back bytes never see valid dropped and raised in one step.
	task automatic send_byte(input logic [BYTE_W-1:0] b);
		int unsigned gap;
		gap = rx_burst ? 0 : $urandom_range(0, MAX_IDLE);
		if (gap != 0) begin
			rx_ch.valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		rx_ch.valid <= 1'b1;
		rx_ch.rx_byte <= b;
		@(posedge clk);
		while (!rx_ch.ready)
			@(posedge clk);
		bytes_sent++;
	endtask

	// Mostly uniform payload bytes, with corner values mixed in often enough
	// that delimiters regularly land inside the payload.
	function automatic logic [BYTE_W-1:0] payload_byte();
		if ($urandom_range(0, 9) == 0)
			return corner_bytes[$urandom_range(0, 3)];
		return BYTE_W'($urandom_range(0, 255));
	endfunction

	function automatic logic [BYTE_W-1:0] byte_other_than(input logic [BYTE_W-1:0] a,
			input logic [BYTE_W-1:0] b);
		logic [BYTE_W-1:0] r;
		do
			r = BYTE_W'($urandom_range(0, 255));
		while (r == a || r == b);
		return r;
	endfunction

	task automatic send_payload();
		repeat (PAYLOAD_LEN) send_byte(payload_byte());
	endtask

	// Most sequences are clean frames so that the deframer keeps reaching
	// its trailer states; the rest break it at every phase.
	function automatic frame_kind_e pick_kind();
		int unsigned r;
		r = $urandom_range(0, 99);
		if (r < 55) return FRAME_CLEAN;
		if (r < 65) return FRAME_CR_RUN;
		if (r < 72) return FRAME_BAD_HDR;
		if (r < 79) return FRAME_BAD_TRAIL_LF;
		if (r < 86) return FRAME_BAD_TRAIL_CR;
		if (r < 93) return FRAME_CUT_SHORT;
		return LINE_NOISE;
	endfunction

	task automatic send_frame(input frame_kind_e kind);
		logic [BYTE_W-1:0] spoil;
		// About one sequence in four goes out back to back with no idle gaps.
		rx_burst = ($urandom_range(0, 3) == 0);
		if (kind == LINE_NOISE) begin
			repeat ($urandom_range(1, 6)) send_byte(BYTE_W'($urandom_range(0, 255)));
			return;
		end
		// A run of extra CRs ahead of the header must keep the hunt waiting.
		if (kind == FRAME_CR_RUN)
			repeat ($urandom_range(1, 4)) send_byte(HDR_FIRST);
		send_byte(HDR_FIRST);
		if (kind == FRAME_BAD_HDR) begin
			send_byte(byte_other_than(HDR_FIRST, HDR_SECOND));
			broken_frames++;
		end else begin
			send_byte(HDR_SECOND);
		end
		if (kind == FRAME_CUT_SHORT) begin
			repeat ($urandom_range(1, PAYLOAD_LEN - 1)) send_byte(payload_byte());
			broken_frames++;
			return;
		end
		send_payload();
		if (kind == FRAME_BAD_TRAIL_LF) begin
			// When the wrong trailer byte is a CR, the bytes after it look
			// like a complete frame. The CR must not be taken as a new header
			// start, so that look-alike must give no pose.
			spoil = ($urandom_range(0, 1) != 0) ? TRL_SECOND
				: byte_other_than(TRL_FIRST, TRL_FIRST);
			send_byte(spoil);
			broken_frames++;
			if (spoil == TRL_SECOND) begin
				send_byte(HDR_SECOND);
				send_payload();
			end
			send_byte(TRL_FIRST);
			send_byte(TRL_SECOND);
			return;
		end
		send_byte(TRL_FIRST);
		if (kind == FRAME_BAD_TRAIL_CR) begin
			send_byte(byte_other_than(TRL_SECOND, TRL_SECOND));
			broken_frames++;
		end else begin
			send_byte(TRL_SECOND);
		end
	endtask

	// Byte side: reset, the directed frame, the random mix, then the drain
	// and the verdict.
	initial begin
		arst_n = 1'b0;
		rx_ch.valid <= 1'b0;
		rx_ch.rx_byte <= '0;
		repeat (7) @(posedge clk);
		arst_n <= 1'b1;

		// Directed part, sent back to back. Stray bytes during the hunt, a
		// repeated header CR, then a payload whose six words are all zeros,
		// all ones, all CR, all LF, all zeros and all ones, and a proper trailer.
		rx_burst = 1'b1;
		send_byte(8'h00);
		send_byte(8'hFF);
		send_byte(HDR_SECOND);
		send_byte(HDR_FIRST);
		send_byte(HDR_FIRST);
		send_byte(HDR_SECOND);
		for (int i = 0; i < PAYLOAD_LEN; i++)
			send_byte(corner_bytes[(i / 4) % 4]);
		send_byte(TRL_FIRST);
		send_byte(TRL_SECOND);

		while (bytes_sent < BYTE_TARGET)
			send_frame(pick_kind());
		rx_ch.valid <= 1'b0;

		// Let the checker see the last transfer before looking at what is
		// still outstanding, then leave room for any stray pose to show up.
		@(posedge clk);
		while (expected_pending != 0)
			@(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);

		$display("Sent %0d bytes in clean and broken frames (%0d broken), checked %0d poses,",
			bytes_sent, broken_frames, poses_checked);
		$display("with random idling on both channels and one long output stall.");
		if (mismatch_count == 0)
			$display("SUCCESS");
		else
			$display("FAILURE");
		$finish;
	end

	// Pose side: a random stall before each transfer, stretches with no
	// stall at all, and once a long hold that lets the output register fill
	// so that the deframer has to stall its byte input.
	initial begin
		int unsigned stall;
		pose_ch.ready <= 1'b0;
		@(posedge arst_n);
		forever begin
			if (!long_hold_done && poses_checked >= HOLD_AFTER) begin
				long_hold_done = 1'b1;
				pose_ch.ready <= 1'b0;
				repeat (LONG_HOLD) @(posedge clk);
			end else begin
				if ($urandom_range(0, 15) == 0)
					pose_burst = !pose_burst;
				stall = pose_burst ? 0 : $urandom_range(0, MAX_IDLE);
				if (stall != 0) begin
					pose_ch.ready <= 1'b0;
					repeat (stall) @(posedge clk);
				end
			end
			pose_ch.ready <= 1'b1;
			@(posedge clk);
			while (!pose_ch.valid)
				@(posedge clk);
		end
	end

endmodule
